// ===== design/scpd_pkg.sv =====
// Package for the cumulative part digest block: types, constants, SHA-1 helpers.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package scpd_pkg;

    localparam int unsigned CMD_DEPTH = 4;

    localparam logic [26:0] PART_SIZE_RESET = 27'd32768;   // 2097152 bytes
    localparam logic [26:0] PART_SIZE_MAX   = 27'd67108864;
    localparam logic [60:0] TOTAL_MAX       = {61{1'b1}};
    localparam logic [6:0]  LAST_ROUND      = 7'd79;
    localparam logic [2:0]  LAST_SLOT       = 3'd7;

    // How a queued word closes a part, if at all.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PART  = 2'd1;
    localparam logic [1:0] KIND_FINAL = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] IV_E = 32'hC3D2E1F0;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        logic [1:0]  kind;
        logic [31:0] part_number;
        logic [60:0] byte_end;
    } t_cmd;

    typedef struct packed {
        logic [31:0] hash_a;
        logic [31:0] hash_b;
        logic [31:0] hash_c;
        logic [31:0] hash_d;
        logic [31:0] hash_e;
        logic [31:0] part_number;
        logic [60:0] byte_end;
        logic        is_final;
        logic        status;
    } t_result;

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)      k = 32'h5A827999;
        else if (rnd < 7'd40) k = 32'h6ED9EBA1;
        else if (rnd < 7'd60) k = 32'h8F1BBCDC;
        else                  k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20)      f = (b & c) | (~b & d);
        else if (rnd < 7'd40) f = b ^ c ^ d;
        else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                  f = b ^ c ^ d;
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== design/scpd_front.sv =====
// Front end: accepts file words, keeps byte and part counters and classifies each word.
// Depends on scpd_pkg.
`default_nettype none
module scpd_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [63:0]      i_data_word,
    input  wire logic [3:0]       i_bytes_valid,
    input  wire logic             i_last_of_file,
    input  wire logic [26:0]      i_part_size,
    input  wire logic             i_cmd_full,
    output logic                  o_cmd_push,
    output scpd_pkg::t_cmd        o_cmd
);
    logic [60:0] r_total, n_total;
    logic [32:0] r_bip, n_bip;
    logic [31:0] r_pcount, n_pcount;
    logic        accept;
    logic [3:0]  nb;
    logic [61:0] sum;
    logic [60:0] tot_n;
    logic [32:0] bip_n;
    logic [26:0] blocks;
    logic [32:0] limit;
    logic [31:0] pc_inc;

    assign o_full     = i_cmd_full;
    assign accept     = i_push & ~i_cmd_full;
    assign o_cmd_push = accept;

    always_comb begin
        nb     = (!i_last_of_file || i_bytes_valid > 4'd8) ? 4'd8 : i_bytes_valid;
        sum    = {1'b0, r_total} + 62'(nb);
        tot_n  = sum[61] ? scpd_pkg::TOTAL_MAX : sum[60:0];
        bip_n  = r_bip + 33'(nb);
        if (i_part_size == 27'd0) begin
            blocks = 27'd1;
        end else if (i_part_size > scpd_pkg::PART_SIZE_MAX) begin
            blocks = scpd_pkg::PART_SIZE_MAX;
        end else begin
            blocks = i_part_size;
        end
        limit  = {blocks, 6'b0};
        pc_inc = (&r_pcount) ? r_pcount : r_pcount + 32'd1;

        o_cmd.data        = i_data_word;
        o_cmd.nbytes      = nb;
        o_cmd.last        = i_last_of_file;
        o_cmd.kind        = scpd_pkg::KIND_NONE;
        o_cmd.part_number = 32'd0;
        o_cmd.byte_end    = 61'd0;
        n_total  = tot_n;
        n_bip    = bip_n;
        n_pcount = r_pcount;
        if (i_last_of_file) begin
            n_total  = 61'd0;
            n_bip    = 33'd0;
            n_pcount = 32'd0;
            if (tot_n == 61'd0) begin
                o_cmd.kind = scpd_pkg::KIND_EMPTY;
            end else begin
                o_cmd.kind        = scpd_pkg::KIND_FINAL;
                o_cmd.part_number = pc_inc;
                o_cmd.byte_end    = tot_n;
            end
        end else if (bip_n >= limit) begin
            n_bip             = 33'd0;
            n_pcount          = pc_inc;
            o_cmd.kind        = scpd_pkg::KIND_PART;
            o_cmd.part_number = pc_inc;
            o_cmd.byte_end    = tot_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= 61'd0;
            r_bip    <= 33'd0;
            r_pcount <= 32'd0;
        end else if (accept) begin
            r_total  <= n_total;
            r_bip    <= n_bip;
            r_pcount <= n_pcount;
        end
    end
endmodule
`default_nettype wire

// ===== design/scpd_cmd_queue.sv =====
// Short queue of classified words between the front end and the hash engine.
// Depends on scpd_pkg.
`default_nettype none
module scpd_cmd_queue #(
    parameter int unsigned DEPTH = scpd_pkg::CMD_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire scpd_pkg::t_cmd   i_cmd,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output scpd_pkg::t_cmd        o_cmd
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    scpd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_head, r_tail;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_head];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + PW'(1);
            end
            if (do_pop) begin
                r_head <= (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/scpd_back.sv =====
// Back end: packs words into the block buffer, pads, runs SHA-1 one round per cycle
// and queues results in a two-entry output buffer. Depends on scpd_pkg.
`default_nettype none
module scpd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire scpd_pkg::t_cmd   i_cmd,
    output logic                  o_cmd_pop,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output scpd_pkg::t_result     o_result
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_ROUND  = 3'd2;
    localparam logic [2:0] S_ADD    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_PAD80 = 2'd1;
    localparam logic [1:0] PH_FILL  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [2:0]     r_state;
    logic [1:0]     r_phase;
    logic [2:0]     r_slot;
    logic [6:0]     r_round;
    scpd_pkg::t_cmd r_cmd;
    logic [31:0]    r_buf [16];
    logic [31:0]    r_h [5];
    logic [31:0]    r_a, r_b, r_c, r_d, r_e;

    scpd_pkg::t_result r_rq [2];
    logic              r_rhead;
    logic [1:0]        r_rcount;

    logic [63:0]       padded;
    logic [63:0]       slot_value;
    logic [1:0]        next_phase;
    logic [31:0]       temp;
    logic [31:0]       w_new;
    logic              room;
    logic              do_emit;
    scpd_pkg::t_result res;

    assign room    = (r_rcount != 2'd2);
    assign o_empty = (r_rcount == 2'd0);
    assign o_result = r_rq[r_rhead];
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign do_emit = (r_state == S_FINISH) && (r_cmd.kind != scpd_pkg::KIND_NONE) && room;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < r_cmd.nbytes) begin
                padded[63-8*k -: 8] = r_cmd.data[63-8*k -: 8];
            end else if (4'(k) == r_cmd.nbytes) begin
                padded[63-8*k -: 8] = 8'h80;
            end else begin
                padded[63-8*k -: 8] = 8'h00;
            end
        end

        unique case (r_phase)
            PH_DATA: begin
                slot_value = r_cmd.last ? padded : r_cmd.data;
                if (!r_cmd.last) begin
                    next_phase = PH_DONE;
                end else if (r_cmd.nbytes == 4'd8) begin
                    next_phase = PH_PAD80;
                end else begin
                    next_phase = PH_FILL;
                end
            end
            PH_PAD80: begin
                slot_value = {8'h80, 56'd0};
                next_phase = PH_FILL;
            end
            PH_FILL: begin
                // The length in bits goes into the last slot of the last block.
                slot_value = (r_slot == scpd_pkg::LAST_SLOT) ? {r_cmd.byte_end, 3'b000}
                                                           : 64'd0;
                next_phase = (r_slot == scpd_pkg::LAST_SLOT) ? PH_DONE : PH_FILL;
            end
            default: begin
                slot_value = 64'd0;
                next_phase = PH_DONE;
            end
        endcase

        temp = {r_a[26:0], r_a[31:27]} + scpd_pkg::round_f(r_round, r_b, r_c, r_d)
             + r_e + scpd_pkg::round_k(r_round) + r_buf[0];
        w_new = r_buf[13] ^ r_buf[8] ^ r_buf[2] ^ r_buf[0];
        w_new = {w_new[30:0], w_new[31]};

        res.hash_a      = r_h[0];
        res.hash_b      = r_h[1];
        res.hash_c      = r_h[2];
        res.hash_d      = r_h[3];
        res.hash_e      = r_h[4];
        res.part_number = r_cmd.part_number;
        res.byte_end    = r_cmd.byte_end;
        res.is_final    = (r_cmd.kind != scpd_pkg::KIND_PART);
        res.status      = 1'b0;
        if (r_cmd.kind == scpd_pkg::KIND_EMPTY) begin
            res        = '0;
            res.is_final = 1'b1;
            res.status = 1'b1;
        end
    end

    // Block buffer: slot writes while packing, a sliding schedule window while hashing.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_buf[{r_slot, 1'b0}] <= slot_value[63:32];
            r_buf[{r_slot, 1'b1}] <= slot_value[31:0];
        end else if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[15] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_WRITE && r_slot == scpd_pkg::LAST_SLOT) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_state == S_ROUND) begin
            r_a <= temp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
        if (do_emit) begin
            r_rq[r_rhead ^ r_rcount[0]] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_DONE;
            r_slot   <= 3'd0;
            r_round  <= 7'd0;
            r_h[0]   <= scpd_pkg::IV_A;
            r_h[1]   <= scpd_pkg::IV_B;
            r_h[2]   <= scpd_pkg::IV_C;
            r_h[3]   <= scpd_pkg::IV_D;
            r_h[4]   <= scpd_pkg::IV_E;
            r_rhead  <= 1'b0;
            r_rcount <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.kind == scpd_pkg::KIND_EMPTY) begin
                            r_phase <= PH_DONE;
                            r_state <= S_FINISH;
                        end else begin
                            r_phase <= PH_DATA;
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_slot  <= r_slot + 3'd1;
                    r_phase <= next_phase;
                    if (r_slot == scpd_pkg::LAST_SLOT) begin
                        r_round <= 7'd0;
                        r_state <= S_ROUND;
                    end else if (next_phase == PH_DONE) begin
                        r_state <= (r_cmd.kind == scpd_pkg::KIND_NONE) ? S_IDLE : S_FINISH;
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 7'd1;
                    if (r_round == scpd_pkg::LAST_ROUND) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    if (r_phase == PH_DONE) begin
                        r_state <= (r_cmd.kind == scpd_pkg::KIND_NONE) ? S_IDLE : S_FINISH;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_FINISH: begin
                    if (r_cmd.kind == scpd_pkg::KIND_NONE) begin
                        r_state <= S_IDLE;
                    end else if (room) begin
                        r_state <= S_IDLE;
                        if (r_cmd.kind != scpd_pkg::KIND_PART) begin
                            // End of file: the hash starts over for the next file.
                            r_slot <= 3'd0;
                            r_h[0] <= scpd_pkg::IV_A;
                            r_h[1] <= scpd_pkg::IV_B;
                            r_h[2] <= scpd_pkg::IV_C;
                            r_h[3] <= scpd_pkg::IV_D;
                            r_h[4] <= scpd_pkg::IV_E;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (do_emit && !(i_pop && !o_empty)) begin
                r_rcount <= r_rcount + 2'd1;
            end else if (!do_emit && i_pop && !o_empty) begin
                r_rcount <= r_rcount - 2'd1;
            end
            if (i_pop && !o_empty) begin
                r_rhead <= ~r_rhead;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/sha1_cumulative_part_digest.sv =====
// Top level of the cumulative part digest: configuration port, front end, queue, back end.
// Depends on scpd_pkg, scpd_front, scpd_cmd_queue and scpd_back.
//
// File bytes enter as 64-bit words through a queue-like port (i_push, o_full); one
// transaction is taken when i_push is high and o_full low. Every file feeds one
// SHA-1 hash. At each part boundary that is not the end of the file a transaction
// with the raw chaining state comes out; at the last word the message is padded and
// the final digest comes out, after which the hash starts over. Results wait in a
// two-entry buffer (o_empty, i_pop) and leave when i_pop is high and o_empty low.
// The front end classifies a word in the cycle it is taken and queues it. The back
// end takes a word only when idle, packs it into the block buffer and runs each full
// 64-byte block through 80 rounds of the single round unit and one add; a finish
// state then writes each result. A final word adds one or two padded blocks; words
// queued ahead of a word delay its result. When results are not popped the back
// end holds, the word queue fills and o_full rises. Reset clears all counters,
// sets the hash state to the SHA-1 initial values and the part size to 32768
// blocks. The user writes part_size_blocks through APB addresses 0 to 3 (paddr[2]
// low) only while the block is idle; the block itself does not enforce this.
`default_nettype none
module sha1_cumulative_part_digest #(
    parameter int unsigned CMD_DEPTH = scpd_pkg::CMD_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_bytes_valid,
    input  wire logic        i_last_of_file,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [31:0]      o_hash_a,
    output logic [31:0]      o_hash_b,
    output logic [31:0]      o_hash_c,
    output logic [31:0]      o_hash_d,
    output logic [31:0]      o_hash_e,
    output logic [31:0]      o_part_number,
    output logic [60:0]      o_end_offset,
    output logic             o_is_final,
    output logic             o_status
);
    logic [26:0]       r_part_size;
    scpd_pkg::t_cmd    front_cmd, queue_cmd;
    logic              front_push, queue_full, queue_valid, back_pop;
    scpd_pkg::t_result result;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {5'd0, r_part_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_size <= scpd_pkg::PART_SIZE_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_part_size <= pwdata[26:0];
        end
    end

    scpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_data_word    (i_data_word),
        .i_bytes_valid  (i_bytes_valid),
        .i_last_of_file (i_last_of_file),
        .i_part_size    (r_part_size),
        .i_cmd_full     (queue_full),
        .o_cmd_push     (front_push),
        .o_cmd          (front_cmd)
    );

    scpd_cmd_queue #(.DEPTH(CMD_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    scpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (back_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (result)
    );

    assign o_hash_a      = result.hash_a;
    assign o_hash_b      = result.hash_b;
    assign o_hash_c      = result.hash_c;
    assign o_hash_d      = result.hash_d;
    assign o_hash_e      = result.hash_e;
    assign o_part_number = result.part_number;
    assign o_end_offset  = result.byte_end;
    assign o_is_final    = result.is_final;
    assign o_status      = result.status;
endmodule
`default_nettype wire

// ===== tb/sv/scpd_checker.sv =====
`timescale 1ns / 1ps
// Checker for the cumulative part digest: follows the APB and queue transactions, predicts
// every result with its own SHA-1 model and compares them. Depends on scpd_pkg.
module scpd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        i_push,
    input  wire logic        o_full,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_bytes_valid,
    input  wire logic        i_last_of_file,
    input  wire logic        o_empty,
    input  wire logic        i_pop,
    input  wire logic [31:0] o_hash_a,
    input  wire logic [31:0] o_hash_b,
    input  wire logic [31:0] o_hash_c,
    input  wire logic [31:0] o_hash_d,
    input  wire logic [31:0] o_hash_e,
    input  wire logic [31:0] o_part_number,
    input  wire logic [60:0] o_end_offset,
    input  wire logic        o_is_final,
    input  wire logic        o_status,
    output int               mismatch_count,
    output int               digests_pending
);
    import scpd_pkg::*;

    localparam logic [2:0] ADDR_PART_SIZE = 3'd0;

    logic [26:0] part_blocks;
    logic [31:0] chain[5];
    logic [31:0] blk_words[16];
    logic [6:0]  blk_fill;
    logic [60:0] file_bytes;
    logic [63:0] part_bytes;
    logic [31:0] parts_closed;
    t_result     digest_q[$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk_words[i];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic absorb_byte(input logic [7:0] v);
        blk_words[blk_fill[5:2]][31 - 8 * blk_fill[1:0] -: 8] = v;
        blk_fill++;
        if (blk_fill == 7'd64) begin
            compress_block();
            blk_fill = 0;
        end
    endtask

    task automatic restart_stream();
        chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D; chain[4] = IV_E;
        blk_fill = 0;
        file_bytes = 0;
        part_bytes = 0;
        parts_closed = 0;
    endtask

    task automatic close_part(input logic fin);
        t_result r;
        if (parts_closed != 32'hFFFF_FFFF) parts_closed++;
        r.hash_a = chain[0]; r.hash_b = chain[1]; r.hash_c = chain[2];
        r.hash_d = chain[3]; r.hash_e = chain[4];
        r.part_number = parts_closed;
        r.byte_end = file_bytes;
        r.is_final = fin;
        r.status = 1'b0;
        digest_q = {digest_q, r};
    endtask

    task automatic take_word(input logic [63:0] data, input logic [3:0] bv, input logic last);
        int unsigned nb;
        logic [63:0] limit;
        logic [63:0] bits;
        t_result r;
        nb = (bv > 8 || !last) ? 8 : bv;
        limit = (part_blocks == 0) ? 64'd1 : (part_blocks > PART_SIZE_MAX ? 64'(PART_SIZE_MAX)
                                                                          : 64'(part_blocks));
        for (int i = 0; i < nb; i++) absorb_byte(data[63 - 8 * i -: 8]);
        file_bytes = (TOTAL_MAX - file_bytes < nb) ? TOTAL_MAX : file_bytes + nb;
        part_bytes += nb;
        if (last) begin
            if (file_bytes == 0) begin
                r = '0;
                r.is_final = 1'b1;
                r.status = 1'b1;
                digest_q = {digest_q, r};
            end else begin
                bits = {file_bytes, 3'b000};
                absorb_byte(8'h80);
                while (blk_fill != 7'd56) absorb_byte(8'h00);
                for (int j = 7; j >= 0; j--) absorb_byte(bits[8 * j +: 8]);
                close_part(1'b1);
            end
            restart_stream();
        end else if (part_bytes >= limit * 64) begin
            part_bytes = 0;
            close_part(1'b0);
        end
    endtask

    task automatic cmp_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            part_blocks = PART_SIZE_RESET;
            restart_stream();
            digest_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_PART_SIZE)
                part_blocks = pwdata[26:0];
            if (i_push && !o_full) take_word(i_data_word, i_bytes_valid, i_last_of_file);
            if (i_pop && !o_empty) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, part_number %h",
                             $time, o_part_number);
                    mismatch_count++;
                end else begin
                    r = digest_q.pop_front();
                    cmp_field("hash_a", r.hash_a, o_hash_a);
                    cmp_field("hash_b", r.hash_b, o_hash_b);
                    cmp_field("hash_c", r.hash_c, o_hash_c);
                    cmp_field("hash_d", r.hash_d, o_hash_d);
                    cmp_field("hash_e", r.hash_e, o_hash_e);
                    cmp_field("part_number", r.part_number, o_part_number);
                    cmp_field("part end", r.byte_end, o_end_offset);
                    cmp_field("is_final", r.is_final, o_is_final);
                    cmp_field("status", r.status, o_status);
                end
            end
        end
        digests_pending = digest_q.size();
    end

    initial begin
        mismatch_count = 0;
        digests_pending = 0;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the cumulative part digest testbench: clock, reset, APB writes, file stimulus
// and result popping. Depends on scpd_pkg, scpd_checker and sha1_cumulative_part_digest.
module tb_top;
    import scpd_pkg::*;

    localparam int          IDLE_LIMIT     = 50000;
    localparam int          DRAIN_CYCLES   = 300;
    localparam int          HOLD_CYCLES    = 3000;
    localparam logic [2:0]  ADDR_PART_SIZE = 3'd0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_push, o_full;
    logic [63:0] i_data_word;
    logic [3:0]  i_bytes_valid;
    logic        i_last_of_file;
    logic        o_empty, i_pop;
    logic [31:0] o_hash_a, o_hash_b, o_hash_c, o_hash_d, o_hash_e, o_part_number;
    logic [60:0] o_end_offset;
    logic        o_is_final, o_status;

    int mismatch_count;
    int digests_pending;
    int words_sent = 0;
    int tx_idle_pct = 18;
    int rx_idle_pct = 56;
    int hold_left = 0;
    bit hold_done = 0;
    int quiet_cycles = 0;
    logic [26:0] cur_blocks = PART_SIZE_RESET;

    always #5 i_clk = ~i_clk;

    sha1_cumulative_part_digest uut (.*);

    scpd_checker u_checker (.*);

    // Result side: random pops, plus one long hold-off to fill the block and stall the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (!hold_done && words_sent >= 1300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [63:0] data, input logic [3:0] bv, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_data_word <= data;
        i_bytes_valid <= bv;
        i_last_of_file <= last;
        do @(posedge i_clk); while (o_full);
        words_sent++;
        if (words_sent == 600) begin
            tx_idle_pct = 56;
            rx_idle_pct = 18;
        end else if (words_sent == 1200) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // Sends nwords words; the final one is marked last unless open_end leaves the file
    // running into the next phase.
    task automatic send_file(input int nwords, input logic [3:0] last_bv, input bit open_end);
        logic [3:0] bv;
        for (int i = 0; i < nwords - 1; i++) begin
            bv = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
            send_word({$urandom, $urandom}, bv, 1'b0);
        end
        if (open_end) send_word({$urandom, $urandom}, 4'd8, 1'b0);
        else send_word({$urandom, $urandom}, last_bv, 1'b1);
    endtask

    task automatic settle_and_write(input logic [31:0] value);
        i_push <= 1'b0;
        @(posedge i_clk);
        while (digests_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PART_SIZE;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_blocks = value[26:0];
    endtask

    initial begin
        logic [31:0] sizes[7];
        int aligned;
        sizes = '{32'd0, 32'd1, 32'd2, 32'd67108864, 32'h07FF_FFFF, 32'd3, 32'd1};
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_push <= 1'b0;
        i_data_word <= '0;
        i_bytes_valid <= '0;
        i_last_of_file <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty files, byte extremes, oversize counts, short non-last word,
        // lengths on both sides of the padding boundary.
        send_word(64'h0, 4'd0, 1'b1);
        send_word({64{1'b1}}, 4'd0, 1'b1);
        send_word({64{1'b1}}, 4'd1, 1'b1);
        send_word(64'h0, 4'd15, 1'b1);
        send_word({32{2'b10}}, 4'd3, 1'b0);
        send_word({32{2'b01}}, 4'd8, 1'b1);
        send_file(7, 4'd7, 1'b0);
        send_file(8, 4'd0, 1'b0);
        send_file(8, 4'd8, 1'b0);

        for (int p = 0; p < 7; p++) begin
            settle_and_write(sizes[p]);
            aligned = (cur_blocks == 0) ? 1 : int'(cur_blocks);
            // A file ending exactly on a part boundary, then a last word with no bytes.
            if (aligned <= 3) send_file(aligned * 8 + 1, 4'd0, 1'b0);
            for (int n = 0; n < 240; ) begin
                int len;
                len = ($urandom_range(7) == 0) ? 1 : $urandom_range(1, 40);
                send_file(len, 4'($urandom_range(15)), $urandom_range(19) == 0);
                n += len;
            end
            // Leave some phases mid-file so the size change lands inside a part.
            if (p % 2 == 1) send_file($urandom_range(1, 12), 4'd8, 1'b1);
        end
        send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);

        i_push <= 1'b0;
        @(posedge i_clk);
        while (digests_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && digests_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sha1_cumulative_part_digest.f =====
design/scpd_pkg.sv
design/scpd_front.sv
design/scpd_cmd_queue.sv
design/scpd_back.sv
design/sha1_cumulative_part_digest.sv
tb/sv/scpd_checker.sv
tb/sv/tb_top.sv
